>>> sv/mfmm_pkg.sv
// Shared types and constants for the monthly frame masked mean block.
package mfmm_pkg;

	localparam int SUM_W = 12;
	localparam int CNT_W = 4;
	localparam int MONTH_W = 4;
	localparam int PIX_W = 8;
	localparam int FP_W = 17;

	localparam logic [PIX_W-1:0] MISSING = 8'hFF;
	localparam logic [MONTH_W-1:0] MONTHS = 4'd12;
	localparam logic [MONTH_W-1:0] FIRST_MONTH = 4'd1;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_END = 2'd1;
	localparam logic [1:0] REG_FRAME = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_DIV
	} state_t;

endpackage

>>> sv/monthly_frame_masked_mean_core.sv
// Top level of the monthly frame masked mean block: accumulator memory, control and divider.
//
// The block takes twelve monthly frames of 8-bit pixels and, during the twelfth frame,
// returns one truncated mean per pixel over the selected months, skipping the missing-data
// code 255 (255 when a pixel has no valid samples). The per-pixel sum and count live in one
// single-port synchronous memory of MAX_PIXELS entries that is read, modified and written
// back for each pixel: the entry is read when a pixel is accepted and written back in ST_MOD.
// In month twelve the mean comes from a bit-serial restoring divider, one quotient bit per
// cycle, the last held while the previous mean waits in the output register. The memory
// needs no clearing pass: month one overwrites every entry.
// Registers (APB, byte addresses): 0x0 start_month, 0x4 end_month, 0x8 frame_pixels.
module monthly_frame_masked_mean_core #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  mean_value,
	output logic        last_pixel,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mfmm_pkg::*;

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int NW = (AW + 1 > FP_W) ? AW + 1 : FP_W;
	localparam int ENT_W = SUM_W + CNT_W;
	localparam int DIV_STEPS = SUM_W;
	localparam int DC_W = $clog2(DIV_STEPS);

	// Configuration registers
	logic [MONTH_W-1:0] start_q;
	logic [MONTH_W-1:0] end_q;
	logic [FP_W-1:0]    frame_q;

	logic cfg_we;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= FIRST_MONTH;
			end_q <= MONTHS;
			frame_q <= FP_W'(1);
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_START: start_q <= pwdata[MONTH_W-1:0];
				REG_END:   end_q <= pwdata[MONTH_W-1:0];
				REG_FRAME: frame_q <= pwdata[FP_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_START: prdata = {{(32-MONTH_W){1'b0}}, start_q};
			REG_END:   prdata = {{(32-MONTH_W){1'b0}}, end_q};
			REG_FRAME: prdata = {{(32-FP_W){1'b0}}, frame_q};
			default:   prdata = '0;
		endcase
	end

	// Position within the year
	state_t state_q, state_d;
	logic [AW-1:0]      idx_q;
	logic [MONTH_W-1:0] month_q;

	logic accept;
	logic mem_we;
	logic div_load;
	logic div_step;
	logic out_load;
	logic last_step;

	// Frame size clamped to 1..MAX_PIXELS, and the month range test.
	logic [NW-1:0] fp_ext;
	logic [NW-1:0] frame_n;
	logic [NW-1:0] frame_last;
	logic          frame_end;
	logic          selected;

	always_comb begin
		fp_ext = NW'(frame_q);
		if (fp_ext == '0) begin
			frame_n = NW'(1);
		end else if (fp_ext > NW'(MAX_PIXELS)) begin
			frame_n = NW'(MAX_PIXELS);
		end else begin
			frame_n = fp_ext;
		end
		frame_last = frame_n - NW'(1);
		frame_end = NW'(idx_q) >= frame_last;
		if (end_q >= start_q) begin
			selected = (month_q >= start_q) && (month_q <= end_q);
		end else begin
			selected = (month_q <= end_q) || (month_q >= start_q);
		end
	end

	// Item decisions captured at acceptance
	logic [PIX_W-1:0] px_s1;
	logic             take_s1;
	logic             fend_s1;
	logic             first_s1;
	logic             final_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= pixel;
			take_s1 <= selected && (pixel != MISSING);
			fend_s1 <= frame_end;
			first_s1 <= month_q <= FIRST_MONTH;
			final_s1 <= month_q >= MONTHS;
		end
	end

	// Accumulator memory: {sum, count} per pixel.
	logic [ENT_W-1:0] mem [MAX_PIXELS];
	logic [ENT_W-1:0] mem_rd_q;
	logic [ENT_W-1:0] mem_wd;

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_rd_q <= mem[idx_q];
		end
		if (mem_we) begin
			mem[idx_q] <= mem_wd;
		end
	end

	logic [SUM_W-1:0] base_sum, new_sum;
	logic [CNT_W-1:0] base_cnt, new_cnt;

	always_comb begin
		if (first_s1) begin
			base_sum = '0;
			base_cnt = '0;
		end else begin
			base_sum = mem_rd_q[ENT_W-1:CNT_W];
			base_cnt = mem_rd_q[CNT_W-1:0];
		end
		if (take_s1) begin
			new_sum = base_sum + SUM_W'(px_s1);
			new_cnt = base_cnt + CNT_W'(1);
		end else begin
			new_sum = base_sum;
			new_cnt = base_cnt;
		end
		mem_wd = {new_sum, new_cnt};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			month_q <= FIRST_MONTH;
		end else if (mem_we) begin
			if (fend_s1) begin
				idx_q <= '0;
				month_q <= (month_q >= MONTHS) ? FIRST_MONTH : month_q + MONTH_W'(1);
			end else begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	// Restoring divider, one quotient bit per cycle; the last step waits until the output register
	// is free. A zero count yields an all-ones quotient, whose low byte is the missing-data code.
	logic [SUM_W-1:0] dq_q;
	logic [CNT_W-1:0] dr_q;
	logic [CNT_W-1:0] dd_q;
	logic [DC_W-1:0]  dcnt_q;
	logic             dlast_q;
	logic [CNT_W:0]   dr_sh;
	logic [CNT_W:0]   dr_diff;
	logic             dbit;
	logic [SUM_W-1:0] dq_next;

	always_comb begin
		dr_sh = {dr_q, dq_q[SUM_W-1]};
		dbit = dr_sh >= {1'b0, dd_q};
		dr_diff = dbit ? dr_sh - {1'b0, dd_q} : dr_sh;
		dq_next = {dq_q[SUM_W-2:0], dbit};
		last_step = dcnt_q == DC_W'(DIV_STEPS - 1);
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			dq_q <= new_sum;
			dr_q <= '0;
			dd_q <= new_cnt;
			dlast_q <= fend_s1;
		end else if (div_step) begin
			dq_q <= dq_next;
			dr_q <= dr_diff[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (div_load) begin
			dcnt_q <= '0;
		end else if (div_step) begin
			dcnt_q <= dcnt_q + DC_W'(1);
		end
	end

	// Output register
	logic             out_valid_q;
	logic [PIX_W-1:0] mean_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_q <= dq_next[PIX_W-1:0];
			last_q <= dlast_q;
		end
	end

	assign out_valid = out_valid_q;
	assign mean_value = mean_q;
	assign last_pixel = last_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MOD;
			end
			ST_MOD: begin
				state_d = final_s1 ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mem_we = 1'b0;
		div_load = 1'b0;
		div_step = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_MOD: begin
				mem_we = 1'b1;
				div_load = final_s1;
			end
			ST_DIV: begin
				out_load = last_step && (!out_valid_q || out_ready);
				div_step = !last_step || out_load;
			end
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

`ifndef SYNTH
	a_accept_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MOD)
		else $error("accepted transaction did not move to the write-back cycle");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(month_q >= FIRST_MONTH) && (month_q <= MONTHS))
		else $error("month counter left the range one to twelve");

	a_out_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DIV)
		else $error("result appeared without a finished division");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> dcnt_q <= DC_W'(DIV_STEPS - 1))
		else $error("divider ran past its last step");

	a_no_write_while_ready: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !in_ready && $past(accept))
		else $error("memory write-back without a preceding accepted transaction");
`endif

endmodule

>>> sim/mfmm_mean_monitor.sv
`timescale 1ns / 100ps
// Monitor for the monthly frame masked mean block: predicts each mean and checks the result.
module mfmm_mean_monitor #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  pixel,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  mean_value,
	input  logic        last_pixel,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending,
	output int          means_checked,
	output int          pixels_seen,
	output logic        year_start
);
	import mfmm_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] mean;
		logic             last;
	} mean_item_t;

	logic [SUM_W-1:0] sum_mem [MAX_PIXELS];
	logic [CNT_W-1:0] cnt_mem [MAX_PIXELS];
	logic [MONTH_W-1:0] start_reg;
	logic [MONTH_W-1:0] end_reg;
	logic [FP_W-1:0] frame_reg;
	logic [MONTH_W-1:0] month_cnt;
	int unsigned pix_idx;
	mean_item_t mean_q[$];

	function automatic bit month_in_range(input logic [MONTH_W-1:0] m);
		if (end_reg >= start_reg)
			return m >= start_reg && m <= end_reg;
		return m <= end_reg || m >= start_reg;
	endfunction

	task automatic write_register(input logic [3:0] addr, input logic [31:0] data);
		case (addr[3:2])
			REG_START: start_reg = data[MONTH_W-1:0];
			REG_END: end_reg = data[MONTH_W-1:0];
			REG_FRAME: frame_reg = data[FP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic accumulate_pixel(input logic [PIX_W-1:0] px);
		int unsigned span;
		int unsigned slot;
		bit take;
		bit frame_end;
		logic [SUM_W-1:0] s;
		logic [CNT_W-1:0] c;
		mean_item_t item;
		span = frame_reg;
		if (span == 0)
			span = 1;
		if (span > MAX_PIXELS)
			span = MAX_PIXELS;
		slot = pix_idx;
		take = month_in_range(month_cnt) && px != MISSING;
		// A frame size shrunk below the current index ends the frame at once.
		frame_end = slot >= span - 1;
		if (slot >= MAX_PIXELS)
			slot = MAX_PIXELS - 1;
		if (month_cnt <= FIRST_MONTH) begin
			s = '0;
			c = '0;
		end else begin
			s = sum_mem[slot];
			c = cnt_mem[slot];
		end
		if (take) begin
			s = s + SUM_W'(px);
			c = c + CNT_W'(1);
		end
		sum_mem[slot] = s;
		cnt_mem[slot] = c;
		if (month_cnt >= MONTHS) begin
			item.mean = (c == 0) ? MISSING : PIX_W'(s / c);
			item.last = frame_end;
			mean_q.push_back(item);
		end
		if (frame_end) begin
			pix_idx = 0;
			month_cnt = (month_cnt >= MONTHS) ? FIRST_MONTH : month_cnt + MONTH_W'(1);
		end else begin
			pix_idx = (slot + 1) & 32'h0000_FFFF;
		end
	endtask

	task automatic check_mean();
		mean_item_t want;
		means_checked++;
		if (mean_q.size() == 0) begin
			errors++;
			$error("unexpected result transaction: mean_value %0d, last_pixel %0d",
				mean_value, last_pixel);
		end else begin
			want = mean_q.pop_front();
			if (mean_value !== want.mean) begin
				errors++;
				$error("mean_value mismatch: expected %0d, got %0d", want.mean, mean_value);
			end
			if (last_pixel !== want.last) begin
				errors++;
				$error("last_pixel mismatch: expected %0d, got %0d", want.last, last_pixel);
			end
		end
	endtask

	// All DUT signals are read before any of this edge's updates land, so the
	// order of events within the time step does not matter.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_reg = FIRST_MONTH;
			end_reg = MONTHS;
			frame_reg = FP_W'(1);
			month_cnt = FIRST_MONTH;
			pix_idx = 0;
			mean_q.delete();
			errors = 0;
			means_checked = 0;
			pixels_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready)
				write_register(paddr, pwdata);
			if (out_valid && out_ready)
				check_mean();
			if (in_valid && in_ready) begin
				accumulate_pixel(pixel);
				pixels_seen++;
			end
		end
		pending = mean_q.size();
		year_start = (month_cnt == FIRST_MONTH) && (pix_idx == 0);
	end

endmodule

>>> sim/monthly_frame_masked_mean_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the monthly frame masked mean block: stimulus, idling and verdict.
module monthly_frame_masked_mean_core_tb;
	import mfmm_pkg::*;

	localparam int LIMIT = 400000;
	localparam int SETTLE_CYCLES = 32;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] pixel = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] mean_value;
	logic last_pixel;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = 4'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;

	int errors;
	int pending;
	int means_checked;
	int pixels_seen;
	logic year_start;

	logic in_taken = 1'b0;
	int cycles = 0;
	int stall_left = 0;
	int sent = 0;
	int years = 0;
	int widest = 1;
	bit quiet = 1'b0;
	bit calm = 1'b0;

	always #4 clk = ~clk;

	monthly_frame_masked_mean_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mean_value(mean_value),
		.last_pixel(last_pixel),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	mfmm_mean_monitor mean_mon (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mean_value(mean_value),
		.last_pixel(last_pixel),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.errors(errors),
		.pending(pending),
		.means_checked(means_checked),
		.pixels_seen(pixels_seen),
		.year_start(year_start)
	);

	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver stalls come in bursts of random length.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && !calm && $urandom_range(0, 11) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 15);
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic [7:0] draw_pixel();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 4)
			return MISSING;
		if (r < 6)
			return 8'd0;
		if (r < 8)
			return 8'd254;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [3:0] draw_month();
		if ($urandom_range(0, 7) == 0)
			return 4'($urandom_range(0, 15));
		return 4'($urandom_range(1, 12));
	endfunction

	task automatic program_reg(input logic [1:0] idx, input int unsigned value);
		logic [31:0] keep;
		keep = (idx == REG_FRAME) ? 32'h0001_FFFF : 32'h0000_000F;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom() & ~keep) | (value & keep);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_pixel(input logic [7:0] p);
		in_valid <= 1'b1;
		pixel <= p;
		do
			@(negedge clk);
		while (!in_taken);
		sent++;
		if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	// Holds off the sender until every mean has come and the block has drained.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic finish_year();
		do
			send_pixel(draw_pixel());
		while (!year_start);
		years++;
	endtask

	task automatic random_year();
		int unsigned frame;
		int unsigned r;
		int unsigned cut;
		calm = ($urandom_range(0, 3) == 0);
		r = $urandom_range(0, 19);
		if (r == 0)
			frame = 0;
		else if (r < 4)
			frame = $urandom_range(7, 24);
		else
			frame = $urandom_range(1, 6);
		settle();
		program_reg(REG_START, draw_month());
		program_reg(REG_END, draw_month());
		program_reg(REG_FRAME, frame);
		if (frame == 0)
			frame = 1;
		if (frame > widest)
			widest = frame;
		// Now and then the year is broken up by a register change in mid-stream.
		// The frame size never grows here, so no sum is read before it is written.
		if ($urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, 12 * frame - 1);
			repeat (cut) send_pixel(draw_pixel());
			settle();
			if ($urandom_range(0, 1) == 0) begin
				program_reg(REG_START, draw_month());
				program_reg(REG_END, draw_month());
			end else begin
				program_reg(REG_FRAME, $urandom_range(0, frame));
			end
		end
		finish_year();
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// One year at the reset settings: single-pixel frames, every month selected.
		send_pixel(8'd0);
		send_pixel(8'd254);
		send_pixel(MISSING);
		send_pixel(8'd17);
		send_pixel(8'd200);
		send_pixel(MISSING);
		send_pixel(8'd3);
		send_pixel(8'd99);
		send_pixel(8'd128);
		send_pixel(MISSING);
		send_pixel(8'd1);
		send_pixel(8'd254);
		years++;

		// Oversized frame, then shrunk to zero in the middle of the first month; the
		// month range moves from everything to nothing, so the mean comes out missing.
		settle();
		program_reg(REG_START, 0);
		program_reg(REG_END, 15);
		program_reg(REG_FRAME, 32'h0001_FFFF);
		program_reg(REG_UNUSED, $urandom());
		send_pixel(MISSING);
		send_pixel(8'd0);
		send_pixel(8'd254);
		settle();
		program_reg(REG_START, 13);
		program_reg(REG_END, 0);
		program_reg(REG_FRAME, 0);
		finish_year();

		while (sent < 440) begin
			if (sent >= 380)
				quiet = 1'b1;
			random_year();
		end
		quiet = 1'b1;
		random_year();

		settle();
		$display("Streamed %0d pixels in %0d yearly passes, frames up to %0d pixels wide,",
			pixels_seen, years, widest);
		$display("with wrapped, empty and full month ranges; %0d means checked.",
			means_checked);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
sv/mfmm_pkg.sv
sv/monthly_frame_masked_mean_core.sv
sim/mfmm_mean_monitor.sv
sim/monthly_frame_masked_mean_core_tb.sv
